>>> rtl/quaternion_rigid_transform_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion rigid transform block
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_RIGID_TRANSFORM_MACROS_SVH
`define QUATERNION_RIGID_TRANSFORM_MACROS_SVH

// Property checked at every rising clock edge.
`define QRT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define QRT_ASSERT_NEXT(name, cond, conseq, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

>>> rtl/qrt_pkg.sv
// ----------------------------------------------------------------------------
// qrt_pkg
// Shared types and constants for the quaternion rigid transform block.
// ----------------------------------------------------------------------------
package qrt_pkg;

  localparam int QuatWidth           = 16;
  localparam int CoordWidth          = 32;
  localparam int QuatFracBitsDefault = 14;
  localparam int CfgIndexWidth       = 3;
  localparam int CfgDataWidth        = (CoordWidth > QuatWidth) ? CoordWidth : QuatWidth;
  localparam int QueueDepth          = 4;
  localparam int QueuePtrWidth       = $clog2(QueueDepth);
  localparam int SettleCycles        = 2;
  localparam int SettleWidth         = 2;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_QUAT_X  = 3'd0,
    REG_QUAT_Y  = 3'd1,
    REG_QUAT_Z  = 3'd2,
    REG_QUAT_W  = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_SHIFT_Z = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] in_x;
    logic signed [CoordWidth-1:0] in_y;
    logic signed [CoordWidth-1:0] in_z;
  } point_in_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] out_x;
    logic signed [CoordWidth-1:0] out_y;
    logic signed [CoordWidth-1:0] out_z;
  } point_out_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
    logic signed [CoordWidth-1:0] z;
  } shift_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Width of one rotation matrix entry: holds 2*q*q products and 1.0 at 2F
  // fraction bits, with sign and one bit of headroom.
  function automatic int entry_width(input int frac_bits);
    int base;
    base = (2 * QuatWidth > 2 * frac_bits) ? 2 * QuatWidth : 2 * frac_bits;
    return base + 2;
  endfunction

endpackage

>>> rtl/qrt_front.sv
// ----------------------------------------------------------------------------
// qrt_front
// Config registers, rotation matrix build, and input request intake.
// ----------------------------------------------------------------------------
module qrt_front #(
  parameter int QUAT_FRAC_BITS = qrt_pkg::QuatFracBitsDefault
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  logic                                                    cfg_we,
  input  logic [qrt_pkg::CfgIndexWidth-1:0]                       cfg_index,
  input  logic [qrt_pkg::CfgDataWidth-1:0]                        cfg_data,
  input  logic                                                    in_valid,
  output logic                                                    in_ready,
  input  qrt_pkg::point_in_t                                      in_data,
  input  qrt_pkg::queue_status_t                                  q_stat,
  output logic                                                    q_push,
  output qrt_pkg::point_in_t                                      q_data,
  output logic [8:0][qrt_pkg::entry_width(QUAT_FRAC_BITS)-1:0]    rot,
  output qrt_pkg::shift_t                                         shift
);
  import qrt_pkg::*;

  localparam int MW = entry_width(QUAT_FRAC_BITS);
  localparam int PW = 2 * QuatWidth;
  localparam logic [QuatWidth-1:0] QuatOne = QuatWidth'(1) << QUAT_FRAC_BITS;
  localparam logic signed [MW-1:0] One = MW'(1) << (2 * QUAT_FRAC_BITS);

  logic signed [QuatWidth-1:0] quat_x, quat_y, quat_z, quat_w;
  logic [SettleWidth-1:0]      settle;

  logic signed [PW-1:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
  logic signed [MW-1:0] exx, eyy, ezz, exy, exz, eyz, exw, eyw, ezw;
  logic [8:0][MW-1:0]   rot_next;

  // Config writes; settle holds off intake until the matrix catches up.
  always_ff @(posedge clk) begin
    if (rst) begin
      quat_x  <= '0;
      quat_y  <= '0;
      quat_z  <= '0;
      quat_w  <= QuatOne;
      shift   <= '0;
      settle  <= SettleWidth'(SettleCycles);
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_QUAT_X:  quat_x  <= cfg_data[QuatWidth-1:0];
          REG_QUAT_Y:  quat_y  <= cfg_data[QuatWidth-1:0];
          REG_QUAT_Z:  quat_z  <= cfg_data[QuatWidth-1:0];
          REG_QUAT_W:  quat_w  <= cfg_data[QuatWidth-1:0];
          REG_SHIFT_X: shift.x <= cfg_data[CoordWidth-1:0];
          REG_SHIFT_Y: shift.y <= cfg_data[CoordWidth-1:0];
          REG_SHIFT_Z: shift.z <= cfg_data[CoordWidth-1:0];
          default: ;
        endcase
        settle <= SettleWidth'(SettleCycles);
      end else if (settle != '0) begin
        settle <= settle - 1'b1;
      end
    end
  end

  // Quaternion cross products, one multiplier each.
  always_ff @(posedge clk) begin
    xx <= quat_x * quat_x;
    yy <= quat_y * quat_y;
    zz <= quat_z * quat_z;
    xy <= quat_x * quat_y;
    xz <= quat_x * quat_z;
    yz <= quat_y * quat_z;
    xw <= quat_x * quat_w;
    yw <= quat_y * quat_w;
    zw <= quat_z * quat_w;
  end

  always_comb begin
    exx = MW'(xx);
    eyy = MW'(yy);
    ezz = MW'(zz);
    exy = MW'(xy);
    exz = MW'(xz);
    eyz = MW'(yz);
    exw = MW'(xw);
    eyw = MW'(yw);
    ezw = MW'(zw);
    rot_next[0] = One - ((eyy + ezz) <<< 1);
    rot_next[1] = (exy - ezw) <<< 1;
    rot_next[2] = (exz + eyw) <<< 1;
    rot_next[3] = (exy + ezw) <<< 1;
    rot_next[4] = One - ((exx + ezz) <<< 1);
    rot_next[5] = (eyz - exw) <<< 1;
    rot_next[6] = (exz - eyw) <<< 1;
    rot_next[7] = (eyz + exw) <<< 1;
    rot_next[8] = One - ((exx + eyy) <<< 1);
  end

  always_ff @(posedge clk) begin
    rot <= rot_next;
  end

  assign in_ready = !q_stat.full && (settle == '0);
  assign q_push   = in_valid && in_ready;
  assign q_data   = in_data;

endmodule

>>> rtl/qrt_queue.sv
// ----------------------------------------------------------------------------
// qrt_queue
// Short FIFO of accepted points between intake and the datapath.
// ----------------------------------------------------------------------------
`include "quaternion_rigid_transform_macros.svh"

module qrt_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  qrt_pkg::point_in_t     push_data,
  input  logic                   pop,
  output qrt_pkg::point_in_t     pop_data,
  output qrt_pkg::queue_status_t stat
);
  import qrt_pkg::*;

  point_in_t                slots [QueueDepth];
  logic [QueuePtrWidth-1:0] wr_ptr, rd_ptr;
  logic [QueuePtrWidth:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign pop_data   = slots[rd_ptr];
  assign stat.full  = (count == (QueuePtrWidth + 1)'(QueueDepth));
  assign stat.empty = (count == '0);

  `QRT_ASSERT(a_no_overflow, push |-> !stat.full, "queue push while full")
  `QRT_ASSERT(a_no_underflow, pop |-> !stat.empty, "queue pop while empty")
  `QRT_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "count did not rise")
  `QRT_ASSERT_NEXT(a_count_down, pop && !push, count == $past(count) - 1'b1, "count did not fall")

endmodule

>>> rtl/qrt_back.sv
// ----------------------------------------------------------------------------
// qrt_back
// Pipelined R*p + t datapath with rounding, saturation and output register.
// ----------------------------------------------------------------------------
module qrt_back #(
  parameter int QUAT_FRAC_BITS = qrt_pkg::QuatFracBitsDefault
) (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  logic [8:0][qrt_pkg::entry_width(QUAT_FRAC_BITS)-1:0] rot,
  input  qrt_pkg::shift_t                                      shift,
  input  qrt_pkg::queue_status_t                               q_stat,
  output logic                                                 q_pop,
  input  qrt_pkg::point_in_t                                   q_data,
  output logic                                                 out_valid,
  input  logic                                                 out_ready,
  output qrt_pkg::point_out_t                                  out_data
);
  import qrt_pkg::*;

  localparam int MW = entry_width(QUAT_FRAC_BITS);
  localparam int W  = CoordWidth;
  localparam int H  = W / 2;              // low half, unsigned
  localparam int HW = W - H;              // high half, signed
  localparam int PW = MW + W;             // exact entry * coordinate
  localparam int AW = MW + W + 2;         // row accumulator
  localparam int F2 = 2 * QUAT_FRAC_BITS;
  localparam int RW = AW - F2;            // after dropping fraction bits
  localparam logic signed [AW-1:0] Half = AW'(1) <<< (F2 - 1);
  localparam logic signed [W-1:0]  MaxV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  MinV = {1'b1, {(W-1){1'b0}}};

  logic adv;
  logic v1, v2, v3, v4;

  logic signed [W-1:0]    coord [3];
  logic signed [W-1:0]    tvec  [3];
  logic signed [MW+H:0]   pp_lo [3][3];
  logic signed [MW+HW-1:0] pp_hi [3][3];
  logic signed [PW-1:0]   prod  [3][3];
  logic signed [AW-1:0]   sum_a [3];
  logic signed [AW-1:0]   sum_b [3];
  logic signed [AW-1:0]   acc   [3];
  logic signed [RW-1:0]   rnd   [3];
  logic signed [W-1:0]    sat   [3];
  point_out_t             out_next;

  // Whole pipeline moves unless a finished result is held at the output.
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && !q_stat.empty;

  assign coord[0] = q_data.in_x;
  assign coord[1] = q_data.in_y;
  assign coord[2] = q_data.in_z;
  assign tvec[0]  = shift.x;
  assign tvec[1]  = shift.y;
  assign tvec[2]  = shift.z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= !q_stat.empty;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // Stage 1: split each coordinate into halves to keep multipliers narrow.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pp_lo[r][c] <= $signed(rot[3*r+c]) * $signed({1'b0, coord[c][H-1:0]});
          pp_hi[r][c] <= $signed(rot[3*r+c]) * $signed(coord[c][W-1:H]);
        end
      end
    end
  end

  // Stage 2: recombine halves into exact products.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= (PW'(pp_hi[r][c]) <<< H) + PW'(pp_lo[r][c]);
        end
      end
    end
  end

  // Stage 3: partial row sums; translation aligned to 2F fraction bits,
  // half LSB folded in for rounding.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        sum_a[r] <= AW'(prod[r][0]) + AW'(prod[r][1]);
        sum_b[r] <= AW'(prod[r][2]) + (AW'(tvec[r]) <<< F2) + Half;
      end
    end
  end

  // Stage 4: full row sum.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        acc[r] <= sum_a[r] + sum_b[r];
      end
    end
  end

  // Floor shift then clamp to the coordinate range.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rnd[r] = acc[r][AW-1:F2];
      if ((&rnd[r][RW-1:W-1]) || !(|rnd[r][RW-1:W-1])) begin
        sat[r] = rnd[r][W-1:0];
      end else begin
        sat[r] = rnd[r][RW-1] ? MinV : MaxV;
      end
    end
    out_next.out_x = sat[0];
    out_next.out_y = sat[1];
    out_next.out_z = sat[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= out_next;
    end
  end

endmodule

>>> rtl/quaternion_rigid_transform.sv
// ----------------------------------------------------------------------------
// quaternion_rigid_transform: rotates each point by a quaternion, adds a shift
// Takes one request per cycle unless stalled by the output or a config write.
// Rate set by the 5-stage multiply/add pipeline; 4-entry queue absorbs stalls.
// Sync reset: identity quaternion, zero shift; in_ready low until matrix settles.
// ----------------------------------------------------------------------------
module quaternion_rigid_transform #(
  parameter int QUAT_FRAC_BITS = qrt_pkg::QuatFracBitsDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [qrt_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [qrt_pkg::CfgDataWidth-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  qrt_pkg::point_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output qrt_pkg::point_out_t               out_data
);
  import qrt_pkg::*;

  localparam int MW = entry_width(QUAT_FRAC_BITS);

  // Front: config registers and the rotation matrix. The matrix is rebuilt
  // from the quaternion in two registered steps (products, then entries), so
  // intake pauses after every config write and after reset until both are done.
  // Writes must wait until no request is in flight; the block does not check.
  logic [8:0][MW-1:0] rot;
  shift_t             shift;

  // Handoff between front and back.
  logic          q_push;
  logic          q_pop;
  point_in_t     q_in;
  point_in_t     q_out;
  queue_status_t q_stat;

  qrt_front #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_in),
    .rot       (rot),
    .shift     (shift)
  );

  // Queue: lets intake keep taking requests, up to its four entries, while the
  // output is stalled, and lets the back drain while intake is idle.
  qrt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  // Back: split multiplies, product recombine, two add levels, then
  // round-half-up, saturate and the output register. The pipeline advances
  // as one whenever the output register is free or being read.
  qrt_back #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .rot       (rot),
    .shift     (shift),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .q_data    (q_out),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for quaternion_rigid_transform
// Streams 3D points through the block under several rotation and shift
// settings and checks every output point against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb;
  import qrt_pkg::*;

  localparam int FRAC = QuatFracBitsDefault;
  localparam logic [CfgIndexWidth-1:0] REG_UNUSED = 3'd7;  // past the register list
  localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [15:0] Q_ONE     = 16'sh4000;    // 1.0 in Q2.14

  localparam cfg_reg_t QUAT_REGS[4]  = '{REG_QUAT_X, REG_QUAT_Y, REG_QUAT_Z, REG_QUAT_W};
  localparam cfg_reg_t SHIFT_REGS[3] = '{REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z};

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     cfg_we    = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  point_in_t                in_data   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  point_out_t               out_data;

  quaternion_rigid_transform u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Shadow copy of the register file, indexed in register order.
  logic signed [15:0] cur_quat[4]  = '{16'sh0, 16'sh0, 16'sh0, Q_ONE};
  logic signed [31:0] cur_shift[3] = '{32'sh0, 32'sh0, 32'sh0};

  point_in_t  point_q[$];     // requests not yet offered to the block
  point_out_t rotated_q[$];   // transformed points owed by the block

  int queued_cnt   = 0;
  int accepted_cnt = 0;
  int checked_cnt  = 0;
  int error_cnt    = 0;
  int setting_cnt  = 1;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic in_taken = 1'b0;      // request accepted at the last rising edge

  initial forever #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor: one row of R*p + t. Entries carry 2F fraction bits, so the
  // exact sum carries 2F too; the shift is aligned to it, then rounded half
  // up and clamped to the 32-bit coordinate range.
  // --------------------------------------------------------------------------
  function automatic logic signed [31:0] apply_row(
    input logic signed [63:0] m0, m1, m2,
    input logic signed [31:0] px, py, pz, t
  );
    logic signed [127:0] acc;
    logic signed [127:0] tt;
    tt  = t;
    acc = m0 * px + m1 * py + m2 * pz + (tt <<< (2 * FRAC));
    acc = (acc + (128'sd1 <<< (2 * FRAC - 1))) >>> (2 * FRAC);
    if (acc > COORD_MAX) return COORD_MAX;
    if (acc < COORD_MIN) return COORD_MIN;
    return acc[31:0];
  endfunction

  // Quaternion is used as written: no normalization, so |q|^2 != 1 scales.
  function automatic point_out_t transform_point(input point_in_t p);
    logic signed [63:0] qx, qy, qz, qw, one;
    logic signed [63:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
    point_out_t r;
    qx  = cur_quat[0];
    qy  = cur_quat[1];
    qz  = cur_quat[2];
    qw  = cur_quat[3];
    one = 64'sd1 <<< (2 * FRAC);
    xx = qx * qx; yy = qy * qy; zz = qz * qz;
    xy = qx * qy; xz = qx * qz; yz = qy * qz;
    xw = qx * qw; yw = qy * qw; zw = qz * qw;
    r.out_x = apply_row(one - 2 * (yy + zz), 2 * (xy - zw), 2 * (xz + yw),
                        p.in_x, p.in_y, p.in_z, cur_shift[0]);
    r.out_y = apply_row(2 * (xy + zw), one - 2 * (xx + zz), 2 * (yz - xw),
                        p.in_x, p.in_y, p.in_z, cur_shift[1]);
    r.out_z = apply_row(2 * (xz - yw), 2 * (yz + xw), one - 2 * (xx + yy),
                        p.in_x, p.in_y, p.in_z, cur_shift[2]);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic signed [31:0] got,
                               input logic signed [31:0] want);
    $display("tb: mismatch %s: got %0d want %0d (result %0d)",
             what, got, want, checked_cnt);
    error_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Register writes happen only with the block idle; the shadow copy follows.
  // Quaternion registers keep the low 16 bits; index past the list is dropped.
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_QUAT_X:  cur_quat[0]  = data[15:0];
      REG_QUAT_Y:  cur_quat[1]  = data[15:0];
      REG_QUAT_Z:  cur_quat[2]  = data[15:0];
      REG_QUAT_W:  cur_quat[3]  = data[15:0];
      REG_SHIFT_X: cur_shift[0] = data;
      REG_SHIFT_Y: cur_shift[1] = data;
      REG_SHIFT_Z: cur_shift[2] = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_quat(input logic signed [15:0] x, y, z, w);
    write_reg(REG_QUAT_X, {16'h0, x});
    write_reg(REG_QUAT_Y, {16'h0, y});
    write_reg(REG_QUAT_Z, {16'h0, z});
    write_reg(REG_QUAT_W, {16'h0, w});
  endtask

  task automatic set_shift(input logic signed [31:0] x, y, z);
    write_reg(REG_SHIFT_X, x);
    write_reg(REG_SHIFT_Y, y);
    write_reg(REG_SHIFT_Z, z);
  endtask

  task automatic queue_point(input logic signed [31:0] x, y, z);
    point_in_t p;
    p.in_x = x;
    p.in_y = y;
    p.in_z = z;
    point_q.push_back(p);
    queued_cnt++;
  endtask

  // Wait for every request to be taken and every result to come back, then
  // cover the pipeline depth before the registers may change.
  task automatic drain();
    while (accepted_cnt != queued_cnt || rotated_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Coordinates: mostly moderate points, some full-range and rail values.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2:       return COORD_MAX;
      3:       return COORD_MIN;
      4, 5, 6: return $signed($urandom_range(2097152)) - 32'sd1048576;
      default: return $signed($urandom_range(536870912)) - 32'sd268435456;
    endcase
  endfunction

  // Mostly near-unit rotations; now and then raw 16-bit components. Junk in
  // the upper data bits of quaternion writes must be ignored.
  task automatic random_setting();
    real a[4];
    real n;
    logic signed [15:0] q;
    do begin
      foreach (a[i]) a[i] = ($itor($urandom_range(20000)) - 10000.0) / 10000.0;
      n = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
    end while (n < 0.05);
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(3) == 0)
        q = $urandom;
      else
        q = $rtoi(a[i] / n * 16384.0);
      write_reg(QUAT_REGS[i], {16'($urandom), q});
    end
    for (int i = 0; i < 3; i++) write_reg(SHIFT_REGS[i], rand_coord());
    setting_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers the next point at the falling edge, holds it until taken.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (point_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= point_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on every accepted request, checks every accepted result
  // against the oldest prediction, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    point_out_t want;
    in_taken = in_valid && in_ready;
    if (in_taken) begin
      rotated_q.push_back(transform_point(in_data));
      accepted_cnt++;
    end
    if (!rst && out_valid && out_ready) begin
      if (rotated_q.size() == 0) begin
        flag_mismatch("result with nothing pending, out_x", out_data.out_x, 32'sd0);
      end else begin
        want = rotated_q.pop_front();
        if (out_data.out_x !== want.out_x) flag_mismatch("out_x", out_data.out_x, want.out_x);
        if (out_data.out_y !== want.out_y) flag_mismatch("out_y", out_data.out_y, want.out_y);
        if (out_data.out_z !== want.out_z) flag_mismatch("out_z", out_data.out_z, want.out_z);
      end
      checked_cnt++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    point_in_t p;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: identity rotation, no shift; points pass straight through.
    queue_point(32'sd0, 32'sd0, 32'sd0);
    queue_point(COORD_MAX, COORD_MAX, COORD_MAX);
    queue_point(COORD_MIN, COORD_MIN, COORD_MIN);
    queue_point(32'sd1, -32'sd1, COORD_MIN);
    queue_point(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0001_0000);
    drain();

    // Tiny x component: y and z diagonals fall just short of 1.0, so
    // +/-2^26 lands exactly on a rounding half. Register write past the
    // list must leave everything as is.
    set_quat(16'sd1, 16'sd0, 16'sd0, Q_ONE);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    setting_cnt++;
    queue_point(32'sd0, 32'sh0400_0000, -32'sh0400_0000);
    queue_point(32'sh0400_0000, -32'sh0400_0000, 32'sh0400_0000);
    queue_point(32'sd3, 32'sh0C00_0000, -32'sh0C00_0000);
    queue_point(-32'sd1, 32'sh0400_0001, -32'sh03FF_FFFF);
    drain();

    // Most negative quaternion and shift: heavy scaling, saturates both ways.
    set_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    set_shift(COORD_MIN, COORD_MIN, COORD_MIN);
    setting_cnt++;
    queue_point(32'sd0, 32'sd0, 32'sd0);
    queue_point(COORD_MAX, COORD_MIN, 32'sd1);
    queue_point(COORD_MIN, COORD_MIN, COORD_MIN);
    queue_point(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000);
    drain();

    // Most positive quaternion and shift.
    set_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    set_shift(COORD_MAX, COORD_MAX, COORD_MAX);
    setting_cnt++;
    queue_point(32'sd0, 32'sd0, 32'sd0);
    queue_point(COORD_MAX, COORD_MAX, COORD_MAX);
    queue_point(COORD_MIN, COORD_MAX, 32'sd0);
    queue_point(-32'sh0001_0000, 32'sh0000_0001, -32'sd7);
    drain();

    // 90 degrees about z (w = z = sqrt(0.5)) with a modest shift.
    set_quat(16'sd0, 16'sd0, 16'sd11585, 16'sd11585);
    set_shift(32'sh0010_0000, -32'sh0020_0000, 32'sh0000_8000);
    setting_cnt++;
    queue_point(32'sh0001_0000, 32'sd0, 32'sd0);
    queue_point(32'sd0, 32'sh0001_0000, 32'sh0002_0000);
    queue_point(32'sh1234_5678, -32'sh0765_4321, 32'sh0000_0001);
    drain();

    // Random settings, cycling through the flow-control modes:
    // free-running, sender idle, receiver stalling, both.
    for (int k = 0; k < 8; k++) begin
      random_setting();
      case (k % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      for (int j = 0; j < 72; j++) begin
        p.in_x = rand_coord();
        p.in_y = rand_coord();
        p.in_z = rand_coord();
        queue_point(p.in_x, p.in_y, p.in_z);
      end
      drain();
    end

    $display("tb: %0d points sent, %0d results checked", queued_cnt, checked_cnt);
    $display("tb: %0d register settings, four flow-control modes", setting_cnt);
    if (error_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #(12 * 200000);
    $display("tb: timeout");
    $display("tb: done, errors");
    $finish;
  end

endmodule
